/* sv/cnpt_pkg.sv */
// Shared types, constants and fixed-point helpers of the comfort-noise power tracker.
package cnpt_pkg;

    localparam int POW_W      = 40;
    localparam int WGT_W      = 32;
    localparam int CNT_W      = 16;
    localparam int IDX_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int PP_W       = 52;

    localparam logic [POW_W-1:0] POW_MAX     = {POW_W{1'b1}};
    localparam logic [POW_W-1:0] NOISE_RESET = 40'd256000000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTHING_ALPHA    = 3'd0,
        REG_TRACK_FRESH_WEIGHT = 3'd1,
        REG_TRACK_KEEP_WEIGHT  = 3'd2,
        REG_SLOW_GROWTH_FACTOR = 3'd3,
        REG_TRANSIENT_ALPHA    = 3'd4,
        REG_NOISE_FLOOR        = 3'd5,
        REG_ONSET_FRAMES       = 3'd6,
        REG_TRANSIENT_FRAMES   = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [WGT_W-1:0] smoothing_alpha;
        logic [WGT_W-1:0] track_fresh_weight;
        logic [WGT_W-1:0] track_keep_weight;
        logic [WGT_W-1:0] slow_growth_factor;
        logic [WGT_W-1:0] transient_alpha;
        logic [POW_W-1:0] noise_floor;
        logic [CNT_W-1:0] onset_frames;
        logic [CNT_W-1:0] transient_frames;
    } cfg_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [POW_W-1:0] power;
        logic             sat;
        logic             fend;
        logic             seed;
        logic             upd_n;
        logic             upd_t;
        logic             clamp_t;
        logic             sel_t;
    } front_t;

    // Partial products of one 40x32 Q2.30 multiply
    typedef struct packed {
        logic [PP_W-1:0] hi;
        logic [PP_W-1:0] lo;
    } pp_t;

    // First half of a Q2.30 multiply: two 20x32 products
    function automatic pp_t qmul_a(input logic [POW_W-1:0] x, input logic [WGT_W-1:0] w);
        pp_t pp;
        pp.hi = PP_W'(x[39:20]) * PP_W'(w);
        pp.lo = PP_W'(x[19:0]) * PP_W'(w);
        return pp;
    endfunction

    // Second half: align, round half up, saturate
    function automatic logic [POW_W-1:0] qmul_b(input pp_t pp);
        logic [52:0] low_sum;
        logic [42:0] r;
        low_sum = {23'd0, pp.hi[9:0], 20'd0} + 53'(pp.lo) + 53'h0000_2000_0000;
        r = 43'(pp.hi[51:10]) + 43'(low_sum[52:30]);
        return (r[42:40] != 3'd0) ? POW_MAX : r[39:0];
    endfunction

    function automatic logic [POW_W-1:0] sat_add(input logic [POW_W-1:0] a,
                                                 input logic [POW_W-1:0] b);
        logic [POW_W:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[POW_W] ? POW_MAX : r[POW_W-1:0];
    endfunction

endpackage

/* sv/cnpt_in_if.sv */
// Request channel carrying one power-spectrum bin.
interface cnpt_in_if;
    import cnpt_pkg::*;

    logic             valid;
    logic             ready;
    logic [POW_W-1:0] bin_power;
    logic             frame_saturated;
    logic             frame_end;

    modport source (output valid, output bin_power, output frame_saturated,
                    output frame_end, input ready);
    modport sink   (input valid, input bin_power, input frame_saturated,
                    input frame_end, output ready);
endinterface

/* sv/cnpt_out_if.sv */
// Result channel carrying one comfort-noise power.
interface cnpt_out_if;
    import cnpt_pkg::*;

    logic             valid;
    logic             ready;
    logic [POW_W-1:0] noise_power;
    logic [IDX_W-1:0] bin_number;
    logic             frame_done;

    modport source (output valid, output noise_power, output bin_number,
                    output frame_done, input ready);
    modport sink   (input valid, input noise_power, input bin_number,
                    input frame_done, output ready);
endinterface

/* sv/comfort_noise_power_tracker_unit.sv */
// Comfort-noise power tracker: one power-spectrum bin in, one noise power out.
//
// Channels: bin_in takes a request per bin (bin_power, frame_saturated,
// frame_end) in bin order; noise_out returns noise_power, bin_number and
// frame_done for each request in the same order. Both use valid/ready and
// move a request at a clock edge where both are high. The configuration
// port writes register cfg_index with cfg_data when cfg_we is high.
// Path: each request passes through a 4-entry queue, a 13-stage update
// pipeline around the per-bin store and an output register.
// Throughput: one bin per cycle while the output can move. A request whose
// bin is still in the update pipeline waits for its write-back.
// Reset: a clearing pass loads every entry of the per-bin store; bin_in
// stays not ready meanwhile, configuration writes still take effect.
// Stall: when noise_out is not ready while a result is held in the output
// register the pipeline holds; the queue keeps taking requests until it
// is full, then bin_in drops ready.
module comfort_noise_power_tracker_unit #(
    parameter int NUM_BINS = 257
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cnpt_in_if.sink                         bin_in,
    cnpt_out_if.source                      noise_out,
    input  logic                            cfg_we,
    input  logic [cnpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cnpt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cnpt_pkg::*;

    cfg_t   cfg;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    logic   push;
    logic   clearing;
    front_t push_item;
    front_t q_head;

    cnpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cnpt_front #(.NUM_BINS(NUM_BINS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .bin_in    (bin_in),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .push_item (push_item)
    );

    cnpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    cnpt_back #(.NUM_BINS(NUM_BINS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .noise_out (noise_out)
    );

endmodule

/* sv/cnpt_cfg.sv */
// Configuration register bank.
module cnpt_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cnpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cnpt_pkg::CFG_DATA_W-1:0] cfg_data,
    output cnpt_pkg::cfg_t                 cfg
);
    import cnpt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SMOOTHING_ALPHA:    cfg_next.smoothing_alpha    = cfg_data[WGT_W-1:0];
                REG_TRACK_FRESH_WEIGHT: cfg_next.track_fresh_weight = cfg_data[WGT_W-1:0];
                REG_TRACK_KEEP_WEIGHT:  cfg_next.track_keep_weight  = cfg_data[WGT_W-1:0];
                REG_SLOW_GROWTH_FACTOR: cfg_next.slow_growth_factor = cfg_data[WGT_W-1:0];
                REG_TRANSIENT_ALPHA:    cfg_next.transient_alpha    = cfg_data[WGT_W-1:0];
                REG_NOISE_FLOOR:        cfg_next.noise_floor        = cfg_data[POW_W-1:0];
                REG_ONSET_FRAMES:       cfg_next.onset_frames       = cfg_data[CNT_W-1:0];
                REG_TRANSIENT_FRAMES:   cfg_next.transient_frames   = cfg_data[CNT_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_alpha    <= 32'd248642666;
            cfg_reg.track_fresh_weight <= 32'd1070346355;
            cfg_reg.track_keep_weight  <= 32'd3395470;
            cfg_reg.slow_growth_factor <= 32'd1074278775;
            cfg_reg.transient_alpha    <= 32'd2682342;
            cfg_reg.noise_floor        <= 40'd17538;
            cfg_reg.onset_frames       <= 16'd20;
            cfg_reg.transient_frames   <= 16'd400;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/cnpt_front.sv */
// Front end: accepts bins, tracks frame count and bin index, classifies each request.
module cnpt_front #(
    parameter int NUM_BINS = 257
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cnpt_pkg::cfg_t    cfg,
    cnpt_in_if.sink           bin_in,
    input  logic              q_full,
    input  logic              clearing,
    output logic              push,
    output cnpt_pkg::front_t  push_item
);
    import cnpt_pkg::*;

    localparam int IW = $clog2(NUM_BINS);

    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic             seeded_reg, seeded_next;
    logic [IW-1:0]    bin_index_reg, bin_index_next;
    logic             c_lt;
    logic [CNT_W-1:0] c1;
    logic             c1_lt;

    // Accept while the queue has room and the store is not being cleared
    assign bin_in.ready = !q_full && !clearing;
    assign push         = bin_in.valid && bin_in.ready;

    // Classify against the frame counter
    always_comb
    begin
        c_lt  = frame_count_reg < cfg.transient_frames;
        c1    = c_lt ? frame_count_reg + 16'd1 : frame_count_reg;
        c1_lt = c1 < cfg.transient_frames;

        push_item.idx     = IDX_W'(bin_index_reg);
        push_item.power   = bin_in.bin_power;
        push_item.sat     = bin_in.frame_saturated;
        push_item.fend    = bin_in.frame_end;
        push_item.seed    = !seeded_reg;
        push_item.upd_n   = frame_count_reg > cfg.onset_frames;
        push_item.upd_t   = c_lt && c1_lt;
        push_item.clamp_t = c1_lt;
        push_item.sel_t   = bin_in.frame_saturated ? c_lt : c1_lt;
    end

    // Advance frame and bin position
    always_comb
    begin
        frame_count_next = frame_count_reg;
        seeded_next      = seeded_reg;
        bin_index_next   = bin_index_reg;
        if (push)
        begin
            if (bin_in.frame_end)
            begin
                if (!bin_in.frame_saturated)
                begin
                    frame_count_next = c1;
                end
                seeded_next    = 1'b1;
                bin_index_next = '0;
            end
            else if (bin_index_reg == IW'(NUM_BINS - 1))
            begin
                bin_index_next = '0;
            end
            else
            begin
                bin_index_next = bin_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            seeded_reg      <= 1'b0;
            bin_index_reg   <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            seeded_reg      <= seeded_next;
            bin_index_reg   <= bin_index_next;
        end
    end

endmodule

/* sv/cnpt_queue.sv */
// Short queue of classified requests between front and back.
module cnpt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cnpt_pkg::front_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output cnpt_pkg::front_t head
);
    import cnpt_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    front_t        slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full  = count_reg == (AW+1)'(DEPTH);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    // Move pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid) else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule

/* sv/cnpt_back.sv */
// Back end: per-bin store, clearing pass, update pipeline and output register.
module cnpt_back #(
    parameter int NUM_BINS = 257
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cnpt_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  cnpt_pkg::front_t q_head,
    output logic             q_pop,
    output logic             clearing,
    cnpt_out_if.source       noise_out
);
    import cnpt_pkg::*;

    localparam int IW   = $clog2(NUM_BINS);
    localparam int LAST = 13;

    typedef struct packed {
        logic [POW_W-1:0] s;
        logic [POW_W-1:0] n;
        logic [POW_W-1:0] t;
    } entry_t;

    typedef struct packed {
        front_t           f;
        logic             dir;
        logic             lt;
        logic [POW_W-1:0] s;
        logic [POW_W-1:0] n;
        logic [POW_W-1:0] t;
        logic [POW_W-1:0] d;
        pp_t              pp1;
        pp_t              pp2;
        pp_t              pp3;
        logic [POW_W-1:0] q1;
        logic [POW_W-1:0] q2;
        logic [POW_W-1:0] q3;
    } work_t;

    entry_t           mem [NUM_BINS];
    entry_t           rd_reg;
    work_t            st_reg [1:LAST];
    work_t            st_next [1:LAST];
    logic             v_reg [1:LAST];
    logic             clr_reg, clr_next;
    logic [IW-1:0]    clr_idx_reg, clr_idx_next;
    logic             ov_reg;
    logic [POW_W-1:0] out_power_reg;
    logic [IDX_W-1:0] out_bin_reg;
    logic             out_done_reg;
    logic             en;
    logic             hazard;
    logic             issue;
    logic [POW_W-1:0] fin_n;
    logic [POW_W-1:0] fin_t;
    logic [POW_W-1:0] fin_out;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    entry_t           wr_data;

    // Pipeline advances whenever the output register can move
    assign en       = !ov_reg || noise_out.ready;
    assign clearing = clr_reg;

    // Hold the head while its bin is still in flight
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 1; k <= LAST; k++)
        begin
            if (v_reg[k] && st_reg[k].f.idx == q_head.idx)
            begin
                hazard = 1'b1;
            end
        end
    end

    assign issue = en && !clr_reg && q_valid && !hazard;
    assign q_pop = issue;

    // Stage datapath
    always_comb
    begin
        st_next[1]   = '0;
        st_next[1].f = q_head;

        // Seed and blend difference for the smoothed power
        st_next[2]   = st_reg[1];
        st_next[2].s = st_reg[1].f.seed ? st_reg[1].f.power : rd_reg.s;
        st_next[2].n = rd_reg.n;
        st_next[2].t = rd_reg.t;
        st_next[2].dir = st_reg[1].f.power >= st_next[2].s;
        st_next[2].d = st_next[2].dir ? st_reg[1].f.power - st_next[2].s
                                      : st_next[2].s - st_reg[1].f.power;

        st_next[3]     = st_reg[2];
        st_next[3].pp1 = qmul_a(st_reg[2].d, cfg.smoothing_alpha);

        st_next[4]    = st_reg[3];
        st_next[4].q1 = qmul_b(st_reg[3].pp1);

        // Apply the smoothing step
        st_next[5] = st_reg[4];
        if (!st_reg[4].f.sat)
        begin
            if (st_reg[4].dir)
            begin
                st_next[5].s = sat_add(st_reg[4].s, st_reg[4].q1);
            end
            else
            begin
                st_next[5].s = (st_reg[4].q1 > st_reg[4].s) ? '0
                                                            : st_reg[4].s - st_reg[4].q1;
            end
        end

        // Tracking-down and growth products
        st_next[6]     = st_reg[5];
        st_next[6].lt  = st_reg[5].s < st_reg[5].n;
        st_next[6].pp1 = qmul_a(st_reg[5].s, cfg.track_fresh_weight);
        st_next[6].pp2 = qmul_a(st_reg[5].n, cfg.track_keep_weight);
        st_next[6].pp3 = qmul_a(st_reg[5].n, cfg.slow_growth_factor);

        st_next[7]    = st_reg[6];
        st_next[7].q1 = qmul_b(st_reg[6].pp1);
        st_next[7].q2 = qmul_b(st_reg[6].pp2);
        st_next[7].q3 = qmul_b(st_reg[6].pp3);

        st_next[8]   = st_reg[7];
        st_next[8].d = sat_add(st_reg[7].q1, st_reg[7].q2);

        st_next[9]     = st_reg[8];
        st_next[9].pp1 = qmul_a(st_reg[8].d, cfg.slow_growth_factor);

        st_next[10]    = st_reg[9];
        st_next[10].q1 = qmul_b(st_reg[9].pp1);

        // Select the new noise estimate and the transient rise
        st_next[11] = st_reg[10];
        if (!st_reg[10].f.sat && st_reg[10].f.upd_n)
        begin
            st_next[11].n = st_reg[10].lt ? st_reg[10].q1 : st_reg[10].q3;
        end
        st_next[11].dir = st_next[11].n > st_reg[10].t;
        st_next[11].d   = st_next[11].n - st_reg[10].t;

        st_next[12]     = st_reg[11];
        st_next[12].pp1 = qmul_a(st_reg[11].d, cfg.transient_alpha);

        st_next[13]    = st_reg[12];
        st_next[13].q1 = qmul_b(st_reg[12].pp1);
    end

    // Final transient update, floor clamps and output select
    always_comb
    begin
        fin_n = st_reg[LAST].n;
        fin_t = st_reg[LAST].t;
        if (!st_reg[LAST].f.sat)
        begin
            if (st_reg[LAST].f.upd_t)
            begin
                fin_t = st_reg[LAST].dir ? sat_add(st_reg[LAST].t, st_reg[LAST].q1)
                                         : st_reg[LAST].n;
            end
            if (fin_n < cfg.noise_floor)
            begin
                fin_n = cfg.noise_floor;
            end
            if (st_reg[LAST].f.clamp_t && fin_t < cfg.noise_floor)
            begin
                fin_t = cfg.noise_floor;
            end
        end
        fin_out = st_reg[LAST].f.sel_t ? fin_t : fin_n;
    end

    // Store write: clearing pass or write-back
    always_comb
    begin
        if (clr_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '{s: '0, n: NOISE_RESET, t: '0};
        end
        else
        begin
            wr_en   = v_reg[LAST] && en;
            wr_addr = st_reg[LAST].f.idx[IW-1:0];
            wr_data = '{s: st_reg[LAST].s, n: fin_n, t: fin_t};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_reg <= mem[q_head.idx[IW-1:0]];
        end
    end

    // Clearing pass after reset
    always_comb
    begin
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg)
        begin
            if (clr_idx_reg == IW'(NUM_BINS - 1))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // Advance the valid bits and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[1] <= issue;
            for (int k = 2; k <= LAST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            ov_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            out_power_reg <= fin_out;
            out_bin_reg   <= st_reg[LAST].f.idx;
            out_done_reg  <= st_reg[LAST].f.fend;
        end
    end

    assign noise_out.valid       = ov_reg;
    assign noise_out.noise_power = out_power_reg;
    assign noise_out.bin_number  = out_bin_reg;
    assign noise_out.frame_done  = out_done_reg;

`ifndef ASSERT_OFF
    a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !issue) else $error("request issued during clearing pass");
    a_no_flight_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !v_reg[LAST]) else $error("write-back collides with clearing");
    a_retire_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && en |=> ov_reg) else $error("retired request lost");
`endif

endmodule
